[design/pss_pkg.sv]
package pss_pkg;
	localparam int CFG_W = 7;
	localparam int IDX_W = 2;
	localparam logic [IDX_W-1:0] REG_LARGEST = 2'd0;
	localparam logic [IDX_W-1:0] REG_SET_SIZE = 2'd1;
	localparam logic [IDX_W-1:0] REG_USE_LIMIT = 2'd2;
	localparam int RUN_W = 12;
	localparam int SIZE_W = 7;
endpackage

[design/postage_stamp_set_search_top.sv]
// Postage-stamp set search. A request with start_req set runs a full search over every
// increasing set of sizes that starts at 1 and emits one result per size of the best
// set, with tlast on the final one; start_req clear, or a set size above the largest
// size, yields no result. The sums table lives in one memory with registered read data;
// per set the block makes a clearing pass over entries 0 to top, then for each size s
// one read-modify-write sweep over sums s to top (two reads and a write per sum; an
// entry that is written is never read in the same cycle), then a scan of sums 1 to top
// and a step to pick the next set, where top is min(use_limit*largest_size, SUM_DEPTH-1).
// The next request is taken once all results have gone out.
module postage_stamp_set_search_top #(
	parameter int MAX_SET = 10,
	parameter int MAX_PIECE = 64,
	parameter int MAX_USES = 32,
	parameter int SUM_DEPTH = 2049
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [pss_pkg::IDX_W-1:0] cfg_index,
	input  logic [pss_pkg::CFG_W-1:0] cfg_data,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,   // [0] start_req
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [23:0]               m_tdata,   // [11:0] best_run, [18:12] piece_size
	output logic                      m_tlast
);
	import pss_pkg::*;

	localparam int AW = $clog2(SUM_DEPTH);
	localparam int CW = $clog2(MAX_USES + 2);
	localparam int NW = $clog2(MAX_SET + 1);
	localparam int PW = $clog2(MAX_PIECE + 1);
	localparam int SW = (PW > SIZE_W) ? PW : SIZE_W;
	localparam int LW = (AW + 1 > RUN_W) ? AW + 1 : RUN_W;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CLEAR = 7'b0000010,
		ST_RD    = 7'b0000100,
		ST_WR    = 7'b0001000,
		ST_SCAN  = 7'b0010000,
		ST_NEXT  = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [6:0] largest_q;
	logic [3:0] set_size_q;
	logic [5:0] use_limit_q;
	logic [PW-1:0] k_q;
	logic [NW-1:0] n_q;
	logic [CW-1:0] t_q;
	logic [AW-1:0] top_q;
	logic [PW-1:0] cur_q [MAX_SET];
	logic [PW-1:0] best_q [MAX_SET];
	logic [LW-1:0] best_len_q, run_q, longest_q;
	logic have_q;
	logic [NW-1:0] idx_q;
	logic [AW:0] v_q;
	logic rd_pending_q;
	logic [NW-1:0] out_q;
	logic [CW-1:0] have_v_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [CW-1:0] wdata, rdata;

	pss_table #(.DEPTH(SUM_DEPTH), .AW(AW), .DW(CW)) u_table (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// Clamped search limits.
	logic [PW-1:0] k_c;
	logic [NW-1:0] n_c;
	logic [CW-1:0] t_c;
	logic [AW+CW+PW:0] prod_c;
	always_comb begin
		k_c = (largest_q == 7'd0) ? PW'(1)
			: (32'(largest_q) > MAX_PIECE) ? PW'(MAX_PIECE) : PW'(largest_q);
		n_c = (set_size_q == 4'd0) ? NW'(1)
			: (32'(set_size_q) > MAX_SET) ? NW'(MAX_SET) : NW'(set_size_q);
		t_c = (use_limit_q == 6'd0) ? CW'(1)
			: (32'(use_limit_q) > MAX_USES) ? CW'(MAX_USES) : CW'(use_limit_q);
		prod_c = (AW+CW+PW+1)'(t_c) * (AW+CW+PW+1)'(k_c);
	end

	// Next-set search: rightmost position that can still grow.
	logic [PW-1:0] s_cur;
	logic found;
	logic [NW-1:0] grow;
	always_comb begin
		s_cur = cur_q[idx_q];
		found = 1'b0;
		grow = '0;
		for (int i = 1; i < MAX_SET; i++) begin
			if (i < 32'(n_q) &&
			    32'(cur_q[i]) < 32'(k_q) - (32'(n_q) - 1 - i)) begin
				found = 1'b1;
				grow = NW'(i);
			end
		end
	end

	// Table addresses and update.
	logic [AW:0] from_c;
	logic [CW-1:0] old_v;
	always_comb begin
		from_c = v_q - (AW+1)'(s_cur);
		old_v = rdata;
		raddr = (state_q == ST_SCAN) ? v_q[AW-1:0]
			: (rd_pending_q ? v_q[AW-1:0] : from_c[AW-1:0]);
		we = 1'b0;
		waddr = v_q[AW-1:0];
		wdata = '0;
		if (state_q == ST_CLEAR) begin
			we = 1'b1;
		end else if (state_q == ST_WR) begin
			if ((from_c == '0 || have_v_q != '0) && have_v_q < t_q &&
			    (old_v == '0 || have_v_q + 1'b1 < old_v)) begin
				we = 1'b1;
				wdata = have_v_q + 1'b1;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_EMIT);
	assign m_tlast = (out_q == n_q - 1'b1);
	always_comb begin
		m_tdata = '0;
		m_tdata[11:0] = best_len_q[RUN_W-1:0];
		m_tdata[18:12] = SIZE_W'(best_q[out_q]);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			largest_q <= 7'd1;
			set_size_q <= 4'd1;
			use_limit_q <= 6'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LARGEST:   largest_q <= cfg_data[6:0];
				REG_SET_SIZE:  set_size_q <= cfg_data[3:0];
				REG_USE_LIMIT: use_limit_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Search sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			have_q <= 1'b0;
			best_len_q <= '0;
			rd_pending_q <= 1'b0;
			idx_q <= '0;
			v_q <= '0;
			out_q <= '0;
			for (int i = 0; i < MAX_SET; i++) begin
				cur_q[i] <= (i == 0) ? PW'(1) : '0;
				best_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tdata[0]) begin
						k_q <= k_c;
						n_q <= n_c;
						t_q <= t_c;
						top_q <= (prod_c > (AW+CW+PW+1)'(SUM_DEPTH - 1))
							? AW'(SUM_DEPTH - 1) : prod_c[AW-1:0];
						have_q <= 1'b0;
						best_len_q <= '0;
						for (int i = 0; i < MAX_SET; i++) begin
							best_q[i] <= '0;
							cur_q[i] <= PW'(i + 1);
						end
						v_q <= '0;
						if (32'(n_c) <= 32'(k_c)) begin
							state_q <= ST_CLEAR;
						end
					end
				end
				ST_CLEAR: begin
					if (v_q[AW-1:0] == top_q) begin
						idx_q <= '0;
						v_q <= (AW+1)'(cur_q[0]);
						rd_pending_q <= 1'b0;
						state_q <= ST_RD;
					end else begin
						v_q <= v_q + 1'b1;
					end
				end
				ST_RD: begin
					// The from-entry is read first, then the target.
					if (!rd_pending_q) begin
						rd_pending_q <= 1'b1;
					end else begin
						have_v_q <= (from_c == '0) ? '0 : rdata;
						rd_pending_q <= 1'b0;
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					if (v_q == (AW+1)'(top_q)) begin
						if (idx_q == n_q - 1'b1) begin
							v_q <= (AW+1)'(1);
							run_q <= '0;
							longest_q <= '0;
							rd_pending_q <= 1'b1;
							state_q <= ST_SCAN;
						end else begin
							idx_q <= idx_q + 1'b1;
							v_q <= (AW+1)'(cur_q[idx_q + 1'b1]);
							state_q <= ST_RD;
						end
					end else begin
						v_q <= v_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_SCAN: begin
					// Read of v issued now; data of v-1 arrives.
					if (!rd_pending_q) begin
						if (rdata != '0) begin
							run_q <= run_q + 1'b1;
							if (run_q + 1'b1 > longest_q) longest_q <= run_q + 1'b1;
						end else begin
							run_q <= '0;
						end
					end
					rd_pending_q <= 1'b0;
					if (v_q == (AW+1)'(top_q) + 1'b1) begin
						state_q <= ST_NEXT;
					end else begin
						v_q <= v_q + 1'b1;
					end
				end
				ST_NEXT: begin
					if (!have_q || longest_q > best_len_q) begin
						have_q <= 1'b1;
						best_len_q <= longest_q;
						best_q <= cur_q;
					end
					if (n_q == NW'(1) || !found) begin
						out_q <= '0;
						state_q <= ST_EMIT;
					end else begin
						for (int i = 1; i < MAX_SET; i++) begin
							if (i == 32'(grow)) cur_q[i] <= cur_q[i] + 1'b1;
							else if (i > 32'(grow)) cur_q[i] <= cur_q[grow] + PW'(i - 32'(grow) + 1);
						end
						v_q <= '0;
						state_q <= ST_CLEAR;
					end
				end
				ST_EMIT: begin
					if (m_tready) begin
						if (m_tlast) state_q <= ST_IDLE;
						else out_q <= out_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	logic unused;
	assign unused = ^{s_tdata[7:1], SW'(0)};
endmodule

[design/pss_table.sv]
// Fewest-pieces table: one synchronous memory, one write port and one read port,
// read data registered.
module pss_table #(
	parameter int DEPTH = 2049,
	parameter int AW = 12,
	parameter int DW = 7
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];

	// Write and read happen in one clocked block.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[design/pss_checker.sv]
module pss_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast
);
	// No new request is taken while results are pending.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("request taken during output");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result moved");

	// The run length is the same across a set's results.
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tdata[11:0] == $past(m_tdata[11:0]))
		else $error("run length changed");

	// After the last result the block is ready again.
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready) else $error("not ready after last");
endmodule

bind postage_stamp_set_search_top pss_checker u_pss_checker (.*);

[tb/pss_checker.sv]
module pss_scoreboard (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [pss_pkg::IDX_W-1:0] cfg_index,
	input  logic [pss_pkg::CFG_W-1:0] cfg_data,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [7:0]                s_tdata,
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [23:0]               m_tdata,
	input  logic                      m_tlast,
	output int                        errors,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import pss_pkg::*;

	localparam int SET_MAX = 10;
	localparam int PIECE_MAX = 64;
	localparam int USES_MAX = 32;
	localparam int SUMS = 2049;

	typedef struct packed {
		logic [RUN_W-1:0]  run;
		logic [SIZE_W-1:0] size;
		logic              last;
	} stamp_result_t;

	stamp_result_t expected_stamps[$];
	logic [6:0] largest_reg;
	logic [3:0] set_size_reg;
	logic [5:0] use_limit_reg;

	function automatic int clamp(int v, int lo, int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Fewest-pieces table over one set, then the longest run of reachable sums.
	function automatic int longest_run(int sizes[SET_MAX], int n, int t, int top);
		int fewest[SUMS];
		int run;
		int best;
		int have;
		run = 0;
		best = 0;
		for (int v = 0; v < SUMS; v++) fewest[v] = 0;
		for (int i = 0; i < n; i++) begin
			for (int v = sizes[i]; v <= top; v++) begin
				have = (v == sizes[i]) ? 0 : fewest[v - sizes[i]];
				if (v != sizes[i] && have == 0) continue;
				if (have >= t) continue;
				if (fewest[v] == 0 || have + 1 < fewest[v]) fewest[v] = have + 1;
			end
		end
		for (int v = 1; v <= top; v++) begin
			if (fewest[v] != 0) begin
				run++;
				if (run > best) best = run;
			end else begin
				run = 0;
			end
		end
		return best;
	endfunction

	// Full search; queues one expected result per size of the first best set.
	function automatic void predict_search();
		int k;
		int n;
		int t;
		int top;
		int len;
		int best_len;
		int i;
		int cur[SET_MAX];
		int best[SET_MAX];
		bit found;
		bit more;
		stamp_result_t r;
		k = clamp(largest_reg, 1, PIECE_MAX);
		n = clamp(set_size_reg, 1, SET_MAX);
		t = clamp(use_limit_reg, 1, USES_MAX);
		top = clamp(t * k, 0, SUMS - 1);
		found = 0;
		best_len = 0;
		if (n > k) return;
		for (int j = 0; j < SET_MAX; j++) cur[j] = (j < n) ? j + 1 : 0;
		do begin
			len = longest_run(cur, n, t, top);
			if (!found || len > best_len) begin
				found = 1;
				best_len = len;
				best = cur;
			end
			// Advance to the next increasing set in lexicographic order.
			more = 0;
			i = n - 1;
			while (i >= 1 && !more) begin
				if (cur[i] < k - (n - 1 - i)) begin
					cur[i]++;
					for (int j = i + 1; j < n; j++) cur[j] = cur[j - 1] + 1;
					more = 1;
				end
				i--;
			end
		end while (more);
		for (int j = 0; j < n; j++) begin
			r.run = best_len[RUN_W-1:0];
			r.size = best[j][SIZE_W-1:0];
			r.last = (j == n - 1);
			expected_stamps.push_back(r);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : p_check
		int bad;
		if (!arst_n) begin
			largest_reg <= 7'd1;
			set_size_reg <= 4'd1;
			use_limit_reg <= 6'd1;
			errors <= 0;
		end else begin
			bad = 0;
			// Register writes.
			if (cfg_we) begin
				case (cfg_index)
					REG_LARGEST: largest_reg <= cfg_data;
					REG_SET_SIZE: set_size_reg <= cfg_data[3:0];
					REG_USE_LIMIT: use_limit_reg <= cfg_data[5:0];
					default: ;
				endcase
			end
			// Accepted request.
			if (s_tvalid && s_tready && s_tdata[0]) predict_search();
			// Accepted result.
			if (m_tvalid && m_tready) begin
				if (expected_stamps.size() == 0) begin
					$error("unexpected result: tdata %h tlast %b", m_tdata, m_tlast);
					bad++;
				end else begin
					stamp_result_t e;
					e = expected_stamps.pop_front();
					if (m_tdata[11:0] !== e.run) begin
						$error("best_run: expected %0d, got %0d", e.run, m_tdata[11:0]);
						bad++;
					end
					if (m_tdata[18:12] !== e.size) begin
						$error("piece_size: expected %0d, got %0d", e.size, m_tdata[18:12]);
						bad++;
					end
					if (m_tlast !== e.last) begin
						$error("last: expected %0b, got %0b", e.last, m_tlast);
						bad++;
					end
				end
			end
			errors <= errors + bad;
		end
	end

	assign pending = expected_stamps.size();
endmodule

[tb/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pss_pkg::*;

	localparam int CYCLE_LIMIT = 20000000;
	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [23:0] m_tdata;
	logic m_tlast;
	int errors;
	int pending;
	int cycles;
	int searches;

	postage_stamp_set_search_top dut (.*);

	pss_scoreboard checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver: one long hold-off while the first results wait, random stalls, a stretch
	// with no stalls, then random stalls again.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		repeat (2000) @(negedge clk) m_tready = 1'b0;
		repeat (300) @(negedge clk) m_tready = ($urandom_range(99) >= 33);
		repeat (20000) @(negedge clk) m_tready = 1'b1;
		forever @(negedge clk) m_tready = ($urandom_range(99) >= 33);
	end

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic configure(int largest, int set_sz, int uses);
		write_reg(REG_LARGEST, CFG_W'(largest));
		write_reg(REG_SET_SIZE, CFG_W'(set_sz));
		write_reg(REG_USE_LIMIT, CFG_W'(uses));
	endtask

	// One request; the sender may idle first.
	task automatic send_request(bit start, bit gaps);
		if (gaps) begin
			while ($urandom_range(99) < 33) @(negedge clk) s_tvalid = 1'b0;
		end
		s_tvalid = 1'b1;
		s_tdata = {7'd0, start};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		s_tvalid = 1'b0;
		if (start) searches++;
	endtask

	// Sender pause: all results in, then time for the block to settle.
	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	task automatic phase(int largest, int set_sz, int uses);
		configure(largest, set_sz, uses);
		send_request(1'b1, 1'b1);
		drain();
	endtask

	initial begin
		cycles = 0;
		searches = 0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Directed: reset settings, an idle request, extremes and clamping.
		send_request(1'b1, 1'b0);
		send_request(1'b0, 1'b0);
		send_request(1'b1, 1'b1);
		drain();
		phase(64, 1, 32);
		phase(127, 1, 63);
		phase(0, 0, 0);
		phase(5, 5, 1);
		phase(3, 5, 2);
		phase(12, 15, 1);
		phase(64, 2, 1);
		phase(6, 3, 3);
		phase(8, 4, 2);
		write_reg(REG_UNUSED, 7'h7f);
		send_request(1'b1, 1'b1);
		send_request(1'b0, 1'b1);
		drain();

		// Random: small settings, bursts of requests; gaps start after a while.
		while (searches < 75) begin
			configure($urandom_range(9, 1), $urandom_range(4, 1), $urandom_range(4, 1));
			repeat ($urandom_range(5, 1)) send_request($urandom_range(99) < 75, searches > 40);
			drain();
		end

		drain();
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

[postage_stamp_set_search_top.f]
design/pss_pkg.sv
design/pss_table.sv
design/postage_stamp_set_search_top.sv
design/pss_checker.sv
tb/pss_checker.sv
tb/tb_top.sv
